// File: hw/rtl/crcfc_pkg.sv
// shared types, constants and the crc byte update for the crc16 frame checker
`timescale 1ns / 1ps

package crcfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // smallest legal frame and fixed overhead: two header, command, length, two crc
    localparam logic [15:0] MIN_FRAME = 16'd6;
    localparam logic [15:0] OVERHEAD  = 16'd6;
    localparam logic [7:0]  MAX_PAYLOAD = 8'd64;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // frame status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_HEADER = 2'd2;
    localparam logic [1:0] STATUS_CRC    = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_FIRST_HEADER  = 8'd0;
    localparam logic [7:0] CFG_SECOND_HEADER = 8'd1;

    typedef struct packed {
        logic [15:0] computed_crc;
        logic [7:0]  payload_length;
        logic [7:0]  command_code;
        logic [1:0]  frame_status;
    } t_result;

    // msb-first crc-16 update over one byte, unrolled into an xor network
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crc16_frame_checker_top.sv
// top level of the crc16 frame checker: input register, frame state, result register
`timescale 1ns / 1ps
// order: an accepted byte is evaluated from the input register by the frame state;
//   the status of a final byte is registered and shown on the master side
// throughput: one byte per cycle; a final byte stalls while an untaken result is held
// reset: synchronous active-low; header registers return to 0xAA and 0x55, frame
//   state clears, both pipeline registers empty

module crc16_frame_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // frame_end
    // master side: one status transaction per frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] frame_status, [9:2] command_code,
                                        // [17:10] payload_length, [33:18] computed_crc,
                                        // [39:34] zero
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]         r_first_header;
    logic [7:0]         r_second_header;

    // input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // result register
    logic               r_out_valid;
    crcfc_pkg::t_result r_out_result;
    crcfc_pkg::t_result w_result;

    logic               w_advance;
    logic               w_s_accept;
    logic               w_m_accept;

    // a byte that ends no frame never waits; a final byte waits for a free result slot
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept = s_axis_tvalid && s_axis_tready;
    assign w_m_accept = r_out_valid && m_axis_tready;

    // config writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_header  <= 8'hAA;
            r_second_header <= 8'h55;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crcfc_pkg::CFG_FIRST_HEADER:  r_first_header  <= i_cfg_data;
                crcfc_pkg::CFG_SECOND_HEADER: r_second_header <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    crcfc_frame_state u_frame_state (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_byte          (r_in_byte),
        .i_last          (r_in_last),
        .i_first_header  (r_first_header),
        .i_second_header (r_second_header),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (w_m_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_result.computed_crc, r_out_result.payload_length,
                            r_out_result.command_code, r_out_result.frame_status};

endmodule

// File: hw/rtl/crcfc_frame_state.sv
// per-frame state and status evaluation for the crc16 frame checker
`timescale 1ns / 1ps

module crcfc_frame_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [7:0]          i_first_header,
    input  logic [7:0]          i_second_header,
    output crcfc_pkg::t_result  o_result
);

    logic [15:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_delay, n_delay;
    logic        r_hdr_ok, n_hdr_ok;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [15:0] w_received;
    logic [15:0] w_expected_total;

    always_comb begin
        n_crc    = (r_count >= 16'd2) ? crcfc_pkg::crc_update(r_crc, r_delay[15:8]) : r_crc;
        n_hdr_ok = r_hdr_ok;
        n_cmd    = r_cmd;
        n_len    = r_len;
        case (r_count)
            16'd0:   n_hdr_ok = (i_byte == i_first_header);
            16'd1:   n_hdr_ok = r_hdr_ok && (i_byte == i_second_header);
            16'd2:   n_cmd    = i_byte;
            16'd3:   n_len    = i_byte;
            default: n_hdr_ok = r_hdr_ok;
        endcase
        n_delay = {r_delay[7:0], i_byte};
        n_count = (r_count != crcfc_pkg::COUNT_MAX) ? r_count + 16'd1 : r_count;
    end

    // trailing crc is little endian: older byte is the low half
    assign w_received       = {n_delay[7:0], n_delay[15:8]};
    assign w_expected_total = crcfc_pkg::OVERHEAD + {8'd0, n_len};

    always_comb begin
        o_result.computed_crc   = n_crc;
        o_result.payload_length = n_len;
        o_result.command_code   = n_cmd;
        if (n_count < crcfc_pkg::MIN_FRAME) begin
            o_result.frame_status = crcfc_pkg::STATUS_LENGTH;
        end else if (!n_hdr_ok) begin
            o_result.frame_status = crcfc_pkg::STATUS_HEADER;
        end else if (n_count != w_expected_total || n_len > crcfc_pkg::MAX_PAYLOAD) begin
            o_result.frame_status = crcfc_pkg::STATUS_LENGTH;
        end else if (n_crc != w_received) begin
            o_result.frame_status = crcfc_pkg::STATUS_CRC;
        end else begin
            o_result.frame_status = crcfc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count  <= 16'd0;
            r_crc    <= crcfc_pkg::CRC_INIT;
            r_delay  <= 16'd0;
            r_hdr_ok <= 1'b1;
            r_cmd    <= 8'd0;
            r_len    <= 8'd0;
        end else if (i_step) begin
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_delay  <= n_delay;
            r_hdr_ok <= n_hdr_ok;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
        end
    end

endmodule
